### design/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// Used by bsa_ctrl, bsa_datapath and bitmap_slot_allocator_core; no dependencies.
package bsa_pkg;

    localparam int WORD_BITS   = 32;
    localparam int INDEX_SPAN  = 256;
    localparam int ADDR_W      = 48;
    localparam int SIZE_W      = 16;
    localparam int COUNT_W     = 9;
    localparam int INDEX_W     = 8;
    localparam int OPCODE_W    = 2;
    localparam int CFG_INDEX_W = 2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_FIND      = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_MARK_USED = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MARK_FREE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_SIZE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT   = 2'd2;

    localparam logic [SIZE_W-1:0]  SLOT_SIZE_RESET  = 16'd64;
    localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 9'd256;

    typedef struct packed {
        logic mark_en;
        logic mark_set;
        logic scan_start;
        logic scan_step;
        logic mul_en;
        logic out_load;
    } bsa_cmd_t;

    typedef struct packed {
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } bsa_status_t;

endpackage

### design/bitmap_slot_allocator_core.sv
// Bitmap slot allocator: keeps one used bit per slot and answers find requests with the
// lowest free slot and its address. A find scans the bitmap one 32-bit word per cycle,
// stopping at the first word with a free slot or at the last word, then multiplies the
// index by the slot size and adds the base address into the result register, waiting
// there while the previous result has not been taken. The bitmap sits in flip-flops
// cleared by reset, so no clearing pass is needed.
// Depends on bsa_pkg, bsa_ctrl and bsa_datapath.
module bitmap_slot_allocator_core #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // opcode[1:0], slot_index[9:2]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,   // found[0], free_index[8:1],
                                                       // slot_address[56:9]
    input  logic                            cfg_wr_en,
    input  logic [bsa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsa_pkg::ADDR_W-1:0]      cfg_wdata
);

    logic [bsa_pkg::OPCODE_W-1:0] s_opcode;
    logic [bsa_pkg::INDEX_W-1:0]  s_slot_index;
    logic                         m_found;
    logic [bsa_pkg::INDEX_W-1:0]  m_free_index;
    logic [bsa_pkg::ADDR_W-1:0]   m_slot_address;
    bsa_pkg::bsa_cmd_t            cmd;
    bsa_pkg::bsa_status_t         status;

    assign s_opcode     = s_tdata[1:0];
    assign s_slot_index = s_tdata[9:2];

    bsa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_opcode (s_opcode),
        .in_ready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    bsa_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_slot_index    (s_slot_index),
        .cmd              (cmd),
        .status           (status),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .out_found        (m_found),
        .out_free_index   (m_free_index),
        .out_slot_address (m_slot_address)
    );

    assign m_tdata = {7'd0, m_slot_address, m_free_index, m_found};

    // A find transaction leaves the input side stalled while it scans
    a_find_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_opcode == bsa_pkg::OP_FIND |=> !s_tready)
        else $error("input ready during find");

    // A new result only appears at the end of a find
    a_result_from_find: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a find in progress");

    // Not-found results carry zero index and address
    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_found |-> m_free_index == '0 && m_slot_address == '0)
        else $error("not-found result with nonzero payload");

endmodule

### design/bsa_ctrl.sv
// Controller state machine of the bitmap slot allocator.
// Depends on bsa_pkg for the command/status structs and opcodes.
module bsa_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [bsa_pkg::OPCODE_W-1:0]  in_opcode,
    output logic                          in_ready,
    input  bsa_pkg::bsa_status_t          status,
    output bsa_pkg::bsa_cmd_t             cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && in_opcode == bsa_pkg::OP_FIND) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_hit || status.scan_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd.mark_en    = accept && (in_opcode == bsa_pkg::OP_MARK_USED ||
                                    in_opcode == bsa_pkg::OP_MARK_FREE);
        cmd.mark_set   = (in_opcode == bsa_pkg::OP_MARK_USED);
        cmd.scan_start = accept && (in_opcode == bsa_pkg::OP_FIND);
        cmd.scan_step  = (state_reg == ST_SCAN);
        cmd.mul_en     = (state_reg == ST_MUL);
        cmd.out_load   = (state_reg == ST_OUT) && status.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### design/bsa_datapath.sv
// Datapath of the bitmap slot allocator: config registers, used bitmap,
// word scanner, address multiply/add and result register. Depends on bsa_pkg.
module bsa_datapath #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bsa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsa_pkg::ADDR_W-1:0]      cfg_wdata,
    input  logic [bsa_pkg::INDEX_W-1:0]     in_slot_index,
    input  bsa_pkg::bsa_cmd_t               cmd,
    output bsa_pkg::bsa_status_t            status,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            out_found,
    output logic [bsa_pkg::INDEX_W-1:0]     out_free_index,
    output logic [bsa_pkg::ADDR_W-1:0]      out_slot_address
);

    localparam int SLOTS    = (MAX_SLOTS < bsa_pkg::INDEX_SPAN) ? MAX_SLOTS
                                                                 : bsa_pkg::INDEX_SPAN;
    localparam int NWORDS   = (SLOTS + bsa_pkg::WORD_BITS - 1) / bsa_pkg::WORD_BITS;
    localparam int MAP_BITS = NWORDS * bsa_pkg::WORD_BITS;
    localparam int MIDX     = $clog2(MAP_BITS);
    localparam int WIDX     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BIT_W    = $clog2(bsa_pkg::WORD_BITS);
    localparam int PROD_W   = bsa_pkg::INDEX_W + bsa_pkg::SIZE_W;

    logic [bsa_pkg::ADDR_W-1:0]  base_reg;
    logic [bsa_pkg::SIZE_W-1:0]  size_reg;
    logic [bsa_pkg::COUNT_W-1:0] count_reg;
    logic [MAP_BITS-1:0]         used_map_reg;
    logic [WIDX-1:0]             wcnt_reg;
    logic                        found_reg;
    logic [bsa_pkg::INDEX_W-1:0] found_idx_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic [bsa_pkg::INDEX_W-1:0] out_idx_reg;
    logic [bsa_pkg::ADDR_W-1:0]  out_addr_reg;

    logic [bsa_pkg::COUNT_W-1:0]   limit;
    logic [bsa_pkg::WORD_BITS-1:0] scan_word;
    logic [bsa_pkg::WORD_BITS-1:0] free_vec;
    logic [bsa_pkg::COUNT_W-1:0]   word_base;
    logic [BIT_W-1:0]              hit_bit;
    logic                          hit;
    logic                          last;
    logic                          mark_ok;

    // Active count: slot_count clipped to min(MAX_SLOTS, 256)
    assign limit = (count_reg > bsa_pkg::COUNT_W'(SLOTS)) ? bsa_pkg::COUNT_W'(SLOTS)
                                                          : count_reg;

    assign mark_ok = ({1'b0, in_slot_index} < limit);

    always_comb begin
        scan_word = used_map_reg[wcnt_reg * bsa_pkg::WORD_BITS +: bsa_pkg::WORD_BITS];
        word_base = bsa_pkg::COUNT_W'(wcnt_reg) << BIT_W;
        for (int b = 0; b < bsa_pkg::WORD_BITS; b++) begin
            free_vec[b] = !scan_word[b] &&
                          ((word_base + bsa_pkg::COUNT_W'(b)) < limit);
        end
        hit_bit = '0;
        for (int b = bsa_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                hit_bit = BIT_W'(b);
            end
        end
    end

    assign hit  = |free_vec;
    assign last = (wcnt_reg == WIDX'(NWORDS - 1));

    assign status.scan_hit  = hit;
    assign status.scan_last = last;
    assign status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            size_reg  <= bsa_pkg::SLOT_SIZE_RESET;
            count_reg <= bsa_pkg::SLOT_COUNT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bsa_pkg::CFG_BASE_ADDRESS: base_reg  <= cfg_wdata;
                bsa_pkg::CFG_SLOT_SIZE:    size_reg  <= cfg_wdata[bsa_pkg::SIZE_W-1:0];
                bsa_pkg::CFG_SLOT_COUNT:   count_reg <= cfg_wdata[bsa_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_map_reg <= '0;
        end else if (cmd.mark_en && mark_ok) begin
            used_map_reg[in_slot_index[MIDX-1:0]] <= cmd.mark_set;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcnt_reg  <= '0;
            found_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            wcnt_reg  <= '0;
            found_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            if (hit) begin
                found_reg <= 1'b1;
            end
            if (!last) begin
                wcnt_reg <= wcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            found_idx_reg <= '0;
        end else if (cmd.scan_step && hit) begin
            found_idx_reg <= bsa_pkg::INDEX_W'(word_base + bsa_pkg::COUNT_W'(hit_bit));
        end
        if (cmd.mul_en) begin
            prod_reg <= found_idx_reg * size_reg;
        end
        if (cmd.out_load) begin
            out_found_reg <= found_reg;
            out_idx_reg   <= found_idx_reg;
            out_addr_reg  <= found_reg ? (base_reg + bsa_pkg::ADDR_W'(prod_reg)) : '0;
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_found        = out_found_reg;
    assign out_free_index   = out_idx_reg;
    assign out_slot_address = out_addr_reg;

endmodule
